@@ rtl/c1d_pkg.sv @@
package c1d_pkg;

  localparam int PIX_W          = 8;
  localparam int TAP_W          = 5;
  localparam int COEF_W         = 16;
  localparam int COEF_WORDS     = 4;
  localparam int COEFS_PER_WORD = 4;
  localparam int CFG_DATA_W     = 64;
  localparam int CFG_IDX_W      = 3;
  localparam int GROUP_SIZE     = 4;
  localparam int ACC_W          = 16;

  typedef logic [PIX_W-1:0]      pixel_t;
  typedef logic [COEF_W-1:0]     coef_t;
  typedef logic [CFG_DATA_W-1:0] coef_word_t;
  typedef logic [CFG_IDX_W-1:0]  cfg_idx_t;
  typedef logic [TAP_W-1:0]      tap_t;
  typedef logic [ACC_W-1:0]      acc_t;

  localparam cfg_idx_t REG_TAP_COUNT = 3'd0;
  localparam cfg_idx_t REG_COEF_0    = 3'd1;
  localparam cfg_idx_t REG_COEF_1    = 3'd2;
  localparam cfg_idx_t REG_COEF_2    = 3'd3;
  localparam cfg_idx_t REG_COEF_3    = 3'd4;

  localparam tap_t   TAP_RESET = 5'd1;
  localparam pixel_t PIX_MAX   = 8'd255;

  typedef struct packed {
    logic valid;
    logic last;
  } stage_ctrl_t;

endpackage

@@ rtl/c1d_in_if.sv @@
interface c1d_in_if;
  logic            valid;
  logic            ready;
  c1d_pkg::pixel_t pixel_in;
  logic            row_end;

  modport source(output valid, output pixel_in, output row_end, input ready);
  modport sink(input valid, input pixel_in, input row_end, output ready);
endinterface

@@ rtl/c1d_out_if.sv @@
interface c1d_out_if;
  logic            valid;
  logic            ready;
  c1d_pkg::pixel_t pixel_out;
  logic            row_done;

  modport source(output valid, output pixel_out, output row_done, input ready);
  modport sink(input valid, input pixel_out, input row_done, output ready);
endinterface

@@ rtl/c1d_window.sv @@
module c1d_window #(
  parameter int MAX_TAPS = 16,
  localparam int CNT_W = $clog2(MAX_TAPS + 1)
) (
  input  logic                             clk,
  input  logic                             rst,
  c1d_in_if.sink                           pix,
  input  logic [CNT_W-1:0]                 taps,
  input  logic                             ready_dn,
  output c1d_pkg::stage_ctrl_t             ctrl,
  output c1d_pkg::pixel_t [MAX_TAPS-1:0]   lanes
);

  localparam int WIN_D = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int IDX_W = (WIN_D > 1) ? $clog2(WIN_D) : 1;

  c1d_pkg::pixel_t                 win [WIN_D];
  c1d_pkg::pixel_t [MAX_TAPS-1:0]  lanes_next;
  c1d_pkg::pixel_t [MAX_TAPS-1:0]  lanes_r;
  logic [CNT_W-1:0]                fill;
  logic [CNT_W-1:0]                fill_inc;
  logic                            valid_r;
  logic                            last_r;
  logic                            accept;
  logic                            emit;

  assign pix.ready = !valid_r || ready_dn;
  assign accept    = pix.valid && pix.ready;
  assign fill_inc  = (fill < CNT_W'(MAX_TAPS)) ? CNT_W'(fill + 1'b1) : fill;
  assign emit      = fill_inc >= taps;

  // lane k is tap k; the newest pixel takes the last active tap
  always_comb begin
    int idx;
    idx = 0;
    for (int k = 0; k < MAX_TAPS; k++) begin
      lanes_next[k] = '0;
      idx = int'(taps) - 2 - k;
      if (k < int'(taps) - 1) begin
        lanes_next[k] = win[idx[IDX_W-1:0]];
      end else if (k == int'(taps) - 1) begin
        lanes_next[k] = pix.pixel_in;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill    <= '0;
      valid_r <= 1'b0;
    end else begin
      if (accept) begin
        fill <= pix.row_end ? '0 : fill_inc;
      end
      if (pix.ready) begin
        valid_r <= accept && emit;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      last_r  <= pix.row_end;
      lanes_r <= lanes_next;
      for (int i = WIN_D - 1; i > 0; i--) begin
        win[i] <= win[i-1];
      end
      win[0] <= pix.pixel_in;
    end
  end

  assign ctrl  = '{valid: valid_r, last: last_r};
  assign lanes = lanes_r;

endmodule

@@ rtl/c1d_mult.sv @@
module c1d_mult #(
  parameter int MAX_TAPS = 16
) (
  input  logic                                             clk,
  input  logic                                             rst,
  input  c1d_pkg::stage_ctrl_t                             ctrl_in,
  input  c1d_pkg::pixel_t [MAX_TAPS-1:0]                   lanes,
  input  c1d_pkg::coef_word_t [c1d_pkg::COEF_WORDS-1:0]    coef_words,
  input  logic                                             ready_dn,
  output logic                                             ready_up,
  output c1d_pkg::stage_ctrl_t                             ctrl_out,
  output c1d_pkg::pixel_t [MAX_TAPS-1:0]                   terms
);

  localparam int PROD_W = c1d_pkg::PIX_W + c1d_pkg::COEF_W;

  logic [PROD_W-1:0]               prod [MAX_TAPS];
  c1d_pkg::pixel_t [MAX_TAPS-1:0]  terms_r;
  logic                            valid_r;
  logic                            last_r;

  for (genvar k = 0; k < MAX_TAPS; k++) begin : g_lane
    c1d_pkg::coef_t coef;
    assign coef = coef_words[k / c1d_pkg::COEFS_PER_WORD]
                  [(k % c1d_pkg::COEFS_PER_WORD) * c1d_pkg::COEF_W +: c1d_pkg::COEF_W];
    assign prod[k] = PROD_W'(lanes[k]) * PROD_W'(coef);
  end

  assign ready_up = !valid_r || ready_dn;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= 1'b0;
    end else if (ready_up) begin
      valid_r <= ctrl_in.valid;
    end
  end

  // Q16 product, integer part only
  always_ff @(posedge clk) begin
    if (ready_up && ctrl_in.valid) begin
      last_r <= ctrl_in.last;
      for (int k = 0; k < MAX_TAPS; k++) begin
        terms_r[k] <= prod[k][PROD_W-1:c1d_pkg::COEF_W];
      end
    end
  end

  assign ctrl_out = '{valid: valid_r, last: last_r};
  assign terms    = terms_r;

endmodule

@@ rtl/c1d_accum.sv @@
module c1d_accum #(
  parameter int MAX_TAPS = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  c1d_pkg::stage_ctrl_t            ctrl_in,
  input  c1d_pkg::pixel_t [MAX_TAPS-1:0]  terms,
  output logic                            ready_up,
  c1d_out_if.source                       res
);

  localparam int GS     = c1d_pkg::GROUP_SIZE;
  localparam int GRP    = (MAX_TAPS + GS - 1) / GS;
  localparam int PART_W = c1d_pkg::PIX_W + $clog2(GS);

  c1d_pkg::pixel_t    padded [GRP*GS];
  logic [PART_W-1:0]  part_next [GRP];
  logic [PART_W-1:0]  part [GRP];
  c1d_pkg::acc_t      acc;
  c1d_pkg::pixel_t    sat;
  logic               valid_a;
  logic               last_a;
  logic               valid_b;
  logic               ready_b;
  c1d_pkg::pixel_t    pixel_b;
  logic               last_b;

  always_comb begin
    for (int i = 0; i < GRP * GS; i++) begin
      padded[i] = '0;
    end
    for (int i = 0; i < MAX_TAPS; i++) begin
      padded[i] = terms[i];
    end
    for (int g = 0; g < GRP; g++) begin
      part_next[g] = '0;
      for (int j = 0; j < GS; j++) begin
        part_next[g] = PART_W'(part_next[g] + PART_W'(padded[g*GS + j]));
      end
    end
  end

  // 16-bit wrap, then signed clamp to 0..255
  always_comb begin
    acc = '0;
    for (int g = 0; g < GRP; g++) begin
      acc = c1d_pkg::ACC_W'(acc + c1d_pkg::ACC_W'(part[g]));
    end
    if (acc[c1d_pkg::ACC_W-1]) begin
      sat = '0;
    end else if (acc > c1d_pkg::ACC_W'(c1d_pkg::PIX_MAX)) begin
      sat = c1d_pkg::PIX_MAX;
    end else begin
      sat = acc[c1d_pkg::PIX_W-1:0];
    end
  end

  assign ready_b  = !valid_b || res.ready;
  assign ready_up = !valid_a || ready_b;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_a <= 1'b0;
      valid_b <= 1'b0;
    end else begin
      if (ready_up) begin
        valid_a <= ctrl_in.valid;
      end
      if (ready_b) begin
        valid_b <= valid_a;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ready_up && ctrl_in.valid) begin
      last_a <= ctrl_in.last;
      part   <= part_next;
    end
    if (ready_b && valid_a) begin
      pixel_b <= sat;
      last_b  <= last_a;
    end
  end

  assign res.valid     = valid_b;
  assign res.pixel_out = pixel_b;
  assign res.row_done  = last_b;

endmodule

@@ rtl/conv1d_u8_q16_kernel.sv @@
// A result is registered through window select, multiply, group sums and final sum/clamp,
// in that order, after the transaction of the pixel that completes its window.
// Throughput: one pixel per cycle; each pipeline stage moves when the one after
// it is empty or moving, and output backpressure holds the whole pipe.
// Reset (rst, synchronous): clears fill count and stage valids, tap_count = 1,
// coefficients = 0; delay line contents are ignored until refilled.
module conv1d_u8_q16_kernel #(
  parameter int MAX_TAPS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  c1d_in_if.sink                      pix,
  c1d_out_if.source                   res,
  input  logic                        cfg_we,
  input  c1d_pkg::cfg_idx_t           cfg_index,
  input  c1d_pkg::coef_word_t         cfg_data
);

  localparam int CNT_W = $clog2(MAX_TAPS + 1);

  c1d_pkg::tap_t                                 tap_count;
  c1d_pkg::coef_word_t [c1d_pkg::COEF_WORDS-1:0] coef_words;
  logic [CNT_W-1:0]                              taps;
  c1d_pkg::stage_ctrl_t                          ctrl_w;
  c1d_pkg::stage_ctrl_t                          ctrl_m;
  c1d_pkg::pixel_t [MAX_TAPS-1:0]                lanes;
  c1d_pkg::pixel_t [MAX_TAPS-1:0]                terms;
  logic                                          ready_m;
  logic                                          ready_a;

  always_ff @(posedge clk) begin
    if (rst) begin
      tap_count  <= c1d_pkg::TAP_RESET;
      coef_words <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        c1d_pkg::REG_TAP_COUNT: tap_count     <= cfg_data[c1d_pkg::TAP_W-1:0];
        c1d_pkg::REG_COEF_0:    coef_words[0] <= cfg_data;
        c1d_pkg::REG_COEF_1:    coef_words[1] <= cfg_data;
        c1d_pkg::REG_COEF_2:    coef_words[2] <= cfg_data;
        c1d_pkg::REG_COEF_3:    coef_words[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  always_comb begin
    if (tap_count == '0) begin
      taps = CNT_W'(1);
    end else if (32'(tap_count) > MAX_TAPS) begin
      taps = CNT_W'(MAX_TAPS);
    end else begin
      taps = CNT_W'(tap_count);
    end
  end

  c1d_window #(.MAX_TAPS(MAX_TAPS)) u_window (
    .clk      (clk),
    .rst      (rst),
    .pix      (pix),
    .taps     (taps),
    .ready_dn (ready_m),
    .ctrl     (ctrl_w),
    .lanes    (lanes)
  );

  c1d_mult #(.MAX_TAPS(MAX_TAPS)) u_mult (
    .clk        (clk),
    .rst        (rst),
    .ctrl_in    (ctrl_w),
    .lanes      (lanes),
    .coef_words (coef_words),
    .ready_dn   (ready_a),
    .ready_up   (ready_m),
    .ctrl_out   (ctrl_m),
    .terms      (terms)
  );

  c1d_accum #(.MAX_TAPS(MAX_TAPS)) u_accum (
    .clk      (clk),
    .rst      (rst),
    .ctrl_in  (ctrl_m),
    .terms    (terms),
    .ready_up (ready_a),
    .res      (res)
  );

endmodule

@@ rtl/c1d_checker.sv @@
module c1d_checker (
  input logic            clk,
  input logic            rst,
  input logic            pix_ready,
  input logic            res_valid,
  input logic            res_ready,
  input c1d_pkg::pixel_t res_pixel_out,
  input logic            res_row_done
);

  a_res_hold: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> res_valid)
    else $error("result dropped while stalled");

  a_res_stable: assert property (@(posedge clk) disable iff (rst)
    res_valid && !res_ready |=> $stable(res_pixel_out) && $stable(res_row_done))
    else $error("result payload changed while stalled");

  // empty output register means the pipe cannot be backed up
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> pix_ready)
    else $error("input stalled with empty output");

  a_reset_clears: assert property (@(posedge clk)
    $past(rst) |-> !res_valid)
    else $error("result valid right after reset");

endmodule

bind conv1d_u8_q16_kernel c1d_checker u_c1d_checker (
  .clk           (clk),
  .rst           (rst),
  .pix_ready     (pix.ready),
  .res_valid     (res.valid),
  .res_ready     (res.ready),
  .res_pixel_out (res.pixel_out),
  .res_row_done  (res.row_done)
);
